[rtl/core/stt_pkg.sv]
// stt_pkg: types, codes and character-class helpers for source_text_tokenizer.
// No dependencies; imported by rtl/core/source_text_tokenizer.sv.
package stt_pkg;

	localparam int OFFSET_BITS = 32;
	localparam int LENGTH_BITS = 16;
	localparam int MAX_RESULTS = 3;

	typedef logic [OFFSET_BITS-1:0] offset_t;
	typedef logic [LENGTH_BITS-1:0] length_t;

	typedef enum logic [2:0] {
		KIND_TOKEN      = 3'd0,
		KIND_END_OK     = 3'd1,
		KIND_UNEXPECTED = 3'd2,
		KIND_BAD_CHAR   = 3'd3,
		KIND_OPEN_STR   = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		MODE_IDLE    = 4'd0,
		MODE_SLASH   = 4'd1,
		MODE_COMMENT = 4'd2,
		MODE_OPEQ    = 4'd3,
		MODE_PLUS    = 4'd4,
		MODE_BAR     = 4'd5,
		MODE_AMP     = 4'd6,
		MODE_MINUS   = 4'd7,
		MODE_NUMBER  = 4'd8,
		MODE_IDENT   = 4'd9,
		MODE_PRIME   = 4'd10,
		MODE_CHAR1   = 4'd11,
		MODE_CHAR2   = 4'd12,
		MODE_STRING  = 4'd13
	} mode_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       has_byte;
		logic       last_byte;
	} tok_in_t;

	typedef struct packed {
		kind_t   result_kind;
		offset_t token_offset;
		length_t token_length;
		logic    last_result;
	} result_t;

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h0A) || (c == 8'h09) || (c == 8'h0D) ||
			(c == 8'h0B) || (c == 8'h0C);
	endfunction

	// one-byte tokens: * % : ; ( ) [ ] , _ . $   (slash handled apart)
	function automatic logic is_single(input logic [7:0] c);
		return (c == 8'h2A) || (c == 8'h25) || (c == 8'h3A) || (c == 8'h3B) ||
			(c == 8'h28) || (c == 8'h29) || (c == 8'h5B) || (c == 8'h5D) ||
			(c == 8'h2C) || (c == CH_UNDER) || (c == 8'h2E) || (c == CH_DOLLAR);
	endfunction

	// first byte of a two-byte "x=" operator: ! = < >
	function automatic logic is_opeq(input logic [7:0] c);
		return (c == 8'h21) || (c == CH_EQ) || (c == 8'h3C) || (c == CH_GT);
	endfunction

endpackage

[rtl/core/source_text_tokenizer.sv]
// source_text_tokenizer: streaming lexer, one source byte per request.
// Depends on rtl/core/stt_pkg.sv.
//
// Usage:
//  - Input channel (in_valid/in_ready/in_data): one request carries one text
//    byte with has_byte and last_byte. A request with has_byte low and
//    last_byte high is a bare end marker; both low is a no-op.
//  - Output channel (out_valid/out_ready/out_data): one result per transfer:
//    a token (offset, length), end-ok, or an error. last_result marks the
//    final result caused by a given input request.
//  - Each request is decoded in the cycle it is accepted and its 0..3 results
//    land in a three-slot result register; they appear on the output from
//    the next cycle, one per cycle while the receiver does not stall.
//  - Throughput: one request per cycle while each request yields at most one
//    result and the receiver does not stall. A request with more than one
//    result holds the input while the single output port drains its slots.
//  - in_ready stays high while the last held result leaves, so a receiver
//    that never stalls sees no bubbles. When the receiver stalls, results
//    wait in the slots and the input stalls once they are not yet drained.
//  - After an error every byte is dropped until the last byte; last_byte
//    always returns the lexer to its reset state (offset 0).
//  - Reset (arst_n low) clears the lexer state and empties the result slots.
module source_text_tokenizer
	import stt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  tok_in_t in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	// lexer state
	mode_t   mode_q;
	offset_t start_q;
	length_t len_q;
	offset_t pos_q;
	logic    err_q;

	// result slots and drain pointer
	result_t    slot_q [MAX_RESULTS];
	logic [1:0] cnt_q;
	logic [1:0] idx_q;

	// next-state and new results
	mode_t      mode_n;
	offset_t    start_n;
	length_t    len_n;
	offset_t    pos_n;
	logic       err_n;
	result_t    res_n [MAX_RESULTS];
	logic [1:0] cnt_n;

	logic in_fire;
	logic out_fire;

	assign out_valid = (idx_q != cnt_q);
	assign out_fire  = out_valid && out_ready;
	assign out_data  = slot_q[idx_q];
	// take a new request when the slots are empty or the last one leaves now
	assign in_ready  = !out_valid || (out_fire && ((idx_q + 2'd1) == cnt_q));
	assign in_fire   = in_valid && in_ready;

	// Decode one byte. Candidate results in model order:
	//   a: pending token closed / mode error, b: one-byte token or unexpected byte,
	//   c: end-of-text close or error, d: end ok.
	always_comb begin
		logic [7:0] c;
		logic       act;
		logic       restart;
		logic [7:0] second;
		result_t    cand [4];
		logic [3:0] cv;
		logic [1:0] n;

		c       = in_data.text_byte;
		act     = !err_q && in_data.has_byte;
		restart = 1'b0;
		second  = 8'h00;
		mode_n  = mode_q;
		start_n = start_q;
		len_n   = len_q;
		pos_n   = pos_q;
		err_n   = err_q;
		cv      = '0;
		for (int i = 0; i < 4; i++) begin
			cand[i] = '{result_kind: KIND_TOKEN, token_offset: '0,
				token_length: '0, last_result: 1'b0};
		end

		if (act) begin
			unique case (mode_q)
				MODE_SLASH: begin
					if (c == CH_SLASH) begin
						mode_n = MODE_COMMENT;
					end else begin
						cv[0]   = 1'b1;
						restart = 1'b1;
					end
				end
				MODE_COMMENT: begin
					if (c == CH_NL) begin
						mode_n = MODE_IDLE;
					end
				end
				MODE_OPEQ:  second = CH_EQ;
				MODE_PLUS:  second = CH_PLUS;
				MODE_BAR:   second = CH_BAR;
				MODE_AMP: begin
					if (c == CH_AMP) begin
						if (len_n != '1) len_n = len_n + 1'b1;
						cv[0] = 1'b1;
					end else begin
						cv[0] = 1'b1;
						cand[0].result_kind = KIND_UNEXPECTED;
						err_n = 1'b1;
					end
					mode_n = MODE_IDLE;
				end
				MODE_MINUS: begin
					if (c == CH_GT) begin
						if (len_n != '1) len_n = len_n + 1'b1;
						cv[0]  = 1'b1;
						mode_n = MODE_IDLE;
					end else if (is_digit(c)) begin
						if (len_n != '1) len_n = len_n + 1'b1;
						mode_n = MODE_NUMBER;
					end else begin
						cv[0]   = 1'b1;
						restart = 1'b1;
					end
				end
				MODE_NUMBER: begin
					if (is_digit(c)) begin
						if (len_n != '1) len_n = len_n + 1'b1;
					end else begin
						cv[0]   = 1'b1;
						restart = 1'b1;
					end
				end
				MODE_IDENT: begin
					if (is_alpha(c) || is_digit(c) || (c == CH_UNDER)) begin
						if (len_n != '1) len_n = len_n + 1'b1;
					end else if (c == CH_QUOTE) begin
						if (len_n != '1) len_n = len_n + 1'b1;
						mode_n = MODE_PRIME;
					end else begin
						cv[0]   = 1'b1;
						restart = 1'b1;
					end
				end
				MODE_PRIME: begin
					if (c == CH_QUOTE) begin
						if (len_n != '1) len_n = len_n + 1'b1;
					end else begin
						cv[0]   = 1'b1;
						restart = 1'b1;
					end
				end
				MODE_CHAR1: begin
					if (len_n != '1) len_n = len_n + 1'b1;
					mode_n = MODE_CHAR2;
				end
				MODE_CHAR2: begin
					if (c == CH_QUOTE) begin
						if (len_n != '1) len_n = len_n + 1'b1;
						cv[0] = 1'b1;
					end else begin
						cv[0] = 1'b1;
						cand[0].result_kind = KIND_BAD_CHAR;
						err_n = 1'b1;
					end
					mode_n = MODE_IDLE;
				end
				MODE_STRING: begin
					if (len_n != '1) len_n = len_n + 1'b1;
					if (c == CH_DQUOTE) begin
						cv[0]  = 1'b1;
						mode_n = MODE_IDLE;
					end
				end
				default: begin
					mode_n  = MODE_IDLE;
					restart = 1'b1;
				end
			endcase

			// two-byte operators: complete on the match, else close and restart
			if (second != 8'h00) begin
				cv[0] = 1'b1;
				if (c == second) begin
					if (len_n != '1) len_n = len_n + 1'b1;
					mode_n = MODE_IDLE;
				end else begin
					restart = 1'b1;
				end
			end

			// closed-token and error fields; errors carry zero length
			if (cand[0].result_kind == KIND_TOKEN) begin
				cand[0].token_offset = start_q;
				cand[0].token_length = len_n;
			end else if (cand[0].result_kind == KIND_BAD_CHAR) begin
				cand[0].token_offset = start_q + OFFSET_BITS'(2);
			end else begin
				cand[0].token_offset = start_q;
			end

			if (restart) begin
				mode_n = MODE_IDLE;
				if (c == CH_SLASH || c == CH_QUOTE || c == CH_DQUOTE ||
					is_opeq(c) || c == CH_PLUS || c == CH_BAR || c == CH_AMP ||
					c == CH_MINUS || is_digit(c) || is_alpha(c)) begin
					start_n = pos_q;
					len_n   = length_t'(1);
				end
				priority if (c == CH_SLASH) begin
					mode_n = MODE_SLASH;
				end else if (is_single(c)) begin
					cv[1] = 1'b1;
					cand[1].token_offset = pos_q;
					cand[1].token_length = length_t'(1);
				end else if (c == CH_QUOTE) begin
					mode_n = MODE_CHAR1;
				end else if (c == CH_DQUOTE) begin
					mode_n = MODE_STRING;
				end else if (is_opeq(c)) begin
					mode_n = MODE_OPEQ;
				end else if (c == CH_PLUS) begin
					mode_n = MODE_PLUS;
				end else if (c == CH_BAR) begin
					mode_n = MODE_BAR;
				end else if (c == CH_AMP) begin
					mode_n = MODE_AMP;
				end else if (c == CH_MINUS) begin
					mode_n = MODE_MINUS;
				end else if (is_digit(c)) begin
					mode_n = MODE_NUMBER;
				end else if (is_alpha(c)) begin
					mode_n = MODE_IDENT;
				end else if (!is_space(c)) begin
					cv[1] = 1'b1;
					cand[1].result_kind  = KIND_UNEXPECTED;
					cand[1].token_offset = pos_q;
					err_n = 1'b1;
				end else begin
					// whitespace: stay idle
					mode_n = MODE_IDLE;
				end
			end

			pos_n = pos_q + 1'b1;
		end

		// end of text: close what is pending, then end ok unless an error
		if (in_data.last_byte) begin
			if (!err_n) begin
				unique case (mode_n)
					MODE_SLASH, MODE_OPEQ, MODE_PLUS, MODE_BAR, MODE_MINUS,
					MODE_NUMBER, MODE_IDENT, MODE_PRIME: begin
						cv[2] = 1'b1;
						cand[2].token_offset = start_n;
						cand[2].token_length = len_n;
					end
					MODE_AMP: begin
						cv[2] = 1'b1;
						cand[2].result_kind  = KIND_UNEXPECTED;
						cand[2].token_offset = start_n;
						err_n = 1'b1;
					end
					MODE_CHAR1, MODE_CHAR2: begin
						cv[2] = 1'b1;
						cand[2].result_kind  = KIND_BAD_CHAR;
						cand[2].token_offset = start_n + OFFSET_BITS'(2);
						err_n = 1'b1;
					end
					MODE_STRING: begin
						cv[2] = 1'b1;
						cand[2].result_kind  = KIND_OPEN_STR;
						cand[2].token_offset = pos_n;
						err_n = 1'b1;
					end
					default: ;
				endcase
				if (!err_n) begin
					cv[3] = 1'b1;
					cand[3].result_kind  = KIND_END_OK;
					cand[3].token_offset = pos_n;
				end
			end
			mode_n  = MODE_IDLE;
			start_n = '0;
			len_n   = '0;
			pos_n   = '0;
			err_n   = 1'b0;
		end

		// pack valid candidates in order into the three slots
		n = 2'd0;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			res_n[i] = cand[0];
		end
		for (int i = 0; i < 4; i++) begin
			if (cv[i] && (n != 2'd3)) begin
				res_n[n] = cand[i];
				n = n + 2'd1;
			end
		end
		if (n != 2'd0) begin
			res_n[n - 2'd1].last_result = 1'b1;
		end
		cnt_n = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			start_q <= '0;
			len_q   <= '0;
			pos_q   <= '0;
			err_q   <= 1'b0;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else if (in_fire) begin
			mode_q  <= mode_n;
			start_q <= start_n;
			len_q   <= len_n;
			pos_q   <= pos_n;
			err_q   <= err_n;
			cnt_q   <= cnt_n;
			idx_q   <= '0;
		end else if (out_fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				slot_q[i] <= res_n[i];
			end
		end
	end

endmodule
